@@ hdl/asm_pkg.sv @@
// Package for the attack signature matcher: signature table, window types
// and result constants. No dependencies.
`timescale 1ns / 1ps

package asm_pkg;

  localparam int unsigned SigCount  = 6;
  localparam int unsigned WinDepth  = 12;
  localparam int unsigned SpanBytes = WinDepth + 1;

  typedef logic [WinDepth-1:0][7:0]  window_t;
  typedef logic [SpanBytes-1:0][7:0] span_t;
  typedef logic [SigCount-1:0]       hits_t;

  // Right-justified: last signature character sits in byte 0 of the span.
  localparam logic [8*SpanBytes-1:0] SIG_TEXT [SigCount] = '{
    "%n%n%n%n",
    "%s%s%s%s",
    "'; DROP TABLE",
    "; rm -rf",
    "../../../",
    "<script>"
  };

  localparam int unsigned SIG_LEN [SigCount] = '{8, 8, 13, 8, 9, 8};

  typedef enum logic [1:0] {
    CAT_NONE     = 2'd0,
    CAT_OVERFLOW = 2'd1,
    CAT_FORMAT   = 2'd2,
    CAT_INJECT   = 2'd3
  } category_e;

  localparam category_e SIG_CAT [SigCount] = '{
    CAT_OVERFLOW, CAT_FORMAT, CAT_INJECT, CAT_INJECT, CAT_INJECT, CAT_INJECT
  };

  localparam logic [3:0] SIG_SEV [SigCount] = '{
    4'd9, 4'd8, 4'd9, 4'd10, 4'd7, 4'd6
  };

endpackage

@@ hdl/asm_sig_match.sv @@
// Signature comparator: checks which signatures end on the newest byte of
// the span. Depends on asm_pkg.
`timescale 1ns / 1ps

module asm_sig_match
  import asm_pkg::*;
(
  input  span_t span_i,
  output hits_t hits_o
);

  always_comb begin
    hits_o = '0;
    for (int s = 0; s < SigCount; s++) begin
      logic match;
      match = 1'b1;
      for (int j = 0; j < SpanBytes; j++) begin
        if (j < SIG_LEN[s] && span_i[j] != SIG_TEXT[s][8*j +: 8]) begin
          match = 1'b0;
        end
      end
      hits_o[s] = match;
    end
  end

endmodule

@@ hdl/attack_signature_matcher_unit.sv @@
// Attack signature matcher top level: input register, byte window, sticky
// hit bits and result register. Depends on asm_pkg and asm_sig_match.
//
// Usage: a string enters one byte per beat on the input channel (in_valid_i,
// in_stall_o, text_byte_i, last_byte_i); last_byte_i marks the final byte.
// For each string exactly one result beat leaves on the output channel
// (out_valid_o, out_stall_i, attack_found_o, rule_index_o,
// attack_category_o, severity_level_o). The reported signature is the
// lowest-numbered one that occurred anywhere in the string.
// Throughput: one byte per cycle while in_stall_o is low; the compare of the
// 13-byte span against all six signatures is combinational.
// Result path: the final byte is held in the input register, then its verdict is captured in the result register.
// Stall: while a result waits, bytes of the next string keep flowing; only
// a further final byte waits in the input register, which then raises
// in_stall_o.
// Reset: window, hit bits and both valid flags clear; no result is pending.
`timescale 1ns / 1ps

module attack_signature_matcher_unit
  import asm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       attack_found_o,
  output logic [2:0] rule_index_o,
  output logic [1:0] attack_category_o,
  output logic [3:0] severity_level_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  window_t    win_q, win_d;
  hits_t      hits_q, hits_d;
  logic       out_valid_q;
  logic       found_q, found_d;
  logic [2:0] index_q, index_d;
  logic [1:0] cat_q, cat_d;
  logic [3:0] sev_q, sev_d;

  logic  s1_blocked;
  logic  s1_fire;
  logic  in_fire;
  logic  out_fire;
  span_t span;
  hits_t match;
  hits_t hits_now;

  assign s1_blocked = s1_valid_q && s1_last_q && out_valid_q && out_stall_i;
  assign s1_fire    = s1_valid_q && !s1_blocked;
  assign in_stall_o = s1_blocked;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  assign span = {win_q, s1_byte_q};

  asm_sig_match u_match (
    .span_i (span),
    .hits_o (match)
  );

  assign hits_now = hits_q | match;

  always_comb begin
    found_d = 1'b0;
    index_d = '0;
    cat_d   = CAT_NONE;
    sev_d   = '0;
    for (int s = SigCount - 1; s >= 0; s--) begin
      if (hits_now[s]) begin
        found_d = 1'b1;
        index_d = 3'(s);
        cat_d   = SIG_CAT[s];
        sev_d   = SIG_SEV[s];
      end
    end
  end

  always_comb begin
    win_d  = win_q;
    hits_d = hits_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        win_d  = '0;
        hits_d = '0;
      end else begin
        win_d  = {win_q[WinDepth-2:0], s1_byte_q};
        hits_d = hits_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      win_q       <= '0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q  <= win_d;
      hits_q <= hits_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (s1_fire && s1_last_q) begin
      found_q <= found_d;
      index_q <= index_d;
      cat_q   <= cat_d;
      sev_q   <= sev_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign attack_found_o    = found_q;
  assign rule_index_o      = index_q;
  assign attack_category_o = cat_q;
  assign severity_level_o  = sev_q;

endmodule

@@ sim/attack_signature_matcher_unit_test.sv @@
// Testbench for attack_signature_matcher_unit: streams strings byte by byte
// and checks each per-string verdict against an in-bench signature scanner
// or, for fixed directed rows, a hand-typed verdict. Depends on asm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module attack_signature_matcher_unit_test;
  import asm_pkg::*;

  typedef struct packed {
    logic       found;
    logic [2:0] rule;
    category_e  cat;
    logic [3:0] sev;
  } verdict_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    bit         fixed;
    verdict_t   want;
  } beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i = 8'h41;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       attack_found_o;
  logic [2:0] rule_index_o;
  logic [1:0] attack_category_o;
  logic [3:0] severity_level_o;

  attack_signature_matcher_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .text_byte_i      (text_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .attack_found_o   (attack_found_o),
    .rule_index_o     (rule_index_o),
    .attack_category_o(attack_category_o),
    .severity_level_o (severity_level_o)
  );

  // Signature table in priority order.
  string      sig_txt [SigCount] = '{"%n%n%n%n", "%s%s%s%s", "'; DROP TABLE",
                                     "; rm -rf", "../../../", "<script>"};
  category_e  sig_cat [SigCount] = '{CAT_OVERFLOW, CAT_FORMAT, CAT_INJECT,
                                     CAT_INJECT, CAT_INJECT, CAT_INJECT};
  logic [3:0] sig_sev [SigCount] = '{4'd9, 4'd8, 4'd9, 4'd10, 4'd7, 4'd6};
  string      noise_pool = "%ns;'DROPTABLE rm-f./<script>";

  // Directed strings; fixed rows carry a hand-typed verdict.
  string    dir_txt   [4] = '{"A", "\001\377", "%n%n%n%n", "<script>%s%s%s%s"};
  bit       dir_fixed [4] = '{1'b1, 1'b1, 1'b1, 1'b0};
  verdict_t dir_want  [4] = '{'{1'b0, 3'd0, CAT_NONE, 4'd0},
                              '{1'b0, 3'd0, CAT_NONE, 4'd0},
                              '{1'b1, 3'd0, CAT_OVERFLOW, 4'd9},
                              '{1'b0, 3'd0, CAT_NONE, 4'd0}};

  int send_idle  [4] = '{0, 70, 0, 38};
  int recv_stall [4] = '{0, 0, 70, 38};

  logic [7:0] window [WinDepth];
  hits_t      seen_rules;
  verdict_t   pending_verdicts [$];
  beat_t      beat_q [$];
  beat_t      on_wire;
  logic [7:0] draft [$];
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         beats_accepted = 0;
  int         error_count = 0;
  logic       long_hold_on = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_400_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Shift a non-final byte into the window; on the final byte produce the verdict and clear the window.
  task automatic scan_byte(input logic [7:0] b, input logic lst,
                           output bit done, output verdict_t v);
    logic [7:0] span [SpanBytes];
    hits_t      h;
    bit         ok;
    int         base;
    for (int i = 0; i < WinDepth; i++) span[i] = window[i];
    span[WinDepth] = b;
    h = seen_rules;
    for (int s = 0; s < SigCount; s++) begin
      base = SpanBytes - sig_txt[s].len();
      ok = 1'b1;
      for (int i = 0; i < sig_txt[s].len(); i++) begin
        if (span[base + i] != sig_txt[s][i]) ok = 1'b0;
      end
      if (ok) h[s] = 1'b1;
    end
    done = lst;
    v = '{1'b0, 3'd0, CAT_NONE, 4'd0};
    if (!lst) begin
      for (int i = 0; i < WinDepth - 1; i++) window[i] = window[i + 1];
      window[WinDepth - 1] = b;
      seen_rules = h;
    end else begin
      for (int s = SigCount - 1; s >= 0; s--) begin
        if (h[s]) v = '{1'b1, 3'(s), sig_cat[s], sig_sev[s]};
      end
      for (int i = 0; i < WinDepth; i++) window[i] = 8'h00;
      seen_rules = '0;
    end
  endtask

  task automatic add_noise();
    if ($urandom_range(99) < 60) draft.push_back(noise_pool[$urandom_range(noise_pool.len() - 1)]);
    else draft.push_back(8'($urandom_range(255, 1)));
  endtask

  task automatic add_signature(input int s, input int mode);
    int idx;
    for (int i = 0; i < sig_txt[s].len(); i++) draft.push_back(sig_txt[s][i]);
    if (mode == 0) begin
      // flip bit 5 of one character (a case flip for letters; a space becomes !)
      idx = draft.size() - 1 - $urandom_range(sig_txt[s].len() - 1);
      draft[idx] = (draft[idx] == 8'h20) ? 8'h21 : draft[idx] ^ 8'h20;
    end else if (mode == 1) begin
      void'(draft.pop_back());
    end
  endtask

  task automatic queue_draft();
    for (int i = 0; i < draft.size(); i++) begin
      beat_q.push_back('{draft[i], i == draft.size() - 1, 1'b0, '0});
    end
  endtask

  task automatic queue_random_string();
    draft.delete();
    repeat ($urandom_range(6)) add_noise();
    if ($urandom_range(99) < 75) add_signature($urandom_range(SigCount - 1), $urandom_range(9));
    if ($urandom_range(99) < 25) add_signature($urandom_range(SigCount - 1), 9);
    repeat ($urandom_range(6)) add_noise();
    if (draft.size() == 0) add_noise();
    queue_draft();
  endtask

  // Input side: prediction on each accepted beat, then present the next one.
  always @(posedge clk_i) begin : drive_input
    bit       done;
    verdict_t v;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        scan_byte(on_wire.data, on_wire.last, done, v);
        if (done) pending_verdicts.push_back(on_wire.fixed ? on_wire.want : v);
        beats_accepted <= beats_accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          on_wire = beat_q.pop_front();
          in_valid_i  <= 1'b1;
          text_byte_i <= on_wire.data;
          last_byte_i <= on_wire.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= long_hold_on || ($urandom_range(99) < stall_pct);
  end

  // Long output hold-off so the block fills and stalls its input.
  initial begin : long_hold
    while (beats_accepted < 60) @(posedge clk_i);
    long_hold_on <= 1'b1;
    repeat (250) @(posedge clk_i);
    long_hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin : check_verdict
    verdict_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict beat with no string pending");
      end else begin
        exp = pending_verdicts.pop_front();
        if (attack_found_o !== exp.found)
          report_mismatch($sformatf("attack_found %b, want %b", attack_found_o, exp.found));
        if (rule_index_o !== exp.rule)
          report_mismatch($sformatf("rule_index %0d, want %0d", rule_index_o, exp.rule));
        if (attack_category_o !== exp.cat)
          report_mismatch($sformatf("attack_category %0d, want %0d",
                                    attack_category_o, exp.cat));
        if (severity_level_o !== exp.sev)
          report_mismatch($sformatf("severity_level %0d, want %0d",
                                    severity_level_o, exp.sev));
      end
    end
  end

  initial begin : run
    int target;
    for (int i = 0; i < WinDepth; i++) window[i] = 8'h00;
    seen_rules = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < dir_txt[r].len(); i++) begin
        beat_q.push_back('{dir_txt[r][i], i == dir_txt[r].len() - 1,
                           dir_fixed[r], dir_want[r]});
      end
    end
    do @(posedge clk_i);
    while (beat_q.size() != 0 || in_valid_i || pending_verdicts.size() != 0);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = send_idle[p];
      stall_pct = recv_stall[p];
      target = beat_q.size() + 100;
      while (beat_q.size() < target) queue_random_string();
      do @(posedge clk_i);
      while (beat_q.size() != 0 || in_valid_i);
    end

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
